@@ design/imh_pkg.sv @@
package imh_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int KEY_BITS_DEF = 31;
   localparam int NVERT = 256;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_DEC     = 2'd1,
      CMD_EXTRACT = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  vertex;
      logic [30:0] key_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  vertex_out;
      logic [30:0] key_out;
      logic        in_heap;
      logic [8:0]  heap_count;
      logic        empty_res;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_POS,
      S_CHECK,
      S_ROOT,
      S_ROOT2,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_L,
      S_DN_CMP,
      S_DONE
   } state_type;

endpackage

@@ design/imh_pos_mem.sv @@
module imh_pos_mem #(
   parameter int PW = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [7:0]    wr_addr,
   input  logic [PW-1:0] wr_data,
   input  logic [7:0]    rd_addr,
   output logic [PW-1:0] rd_data
);
   import imh_pkg::*;

   logic [PW-1:0] mem [NVERT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/imh_heap_mem.sv @@
module imh_heap_mem #(
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 31,
   parameter int AW = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [7:0]          wr_vertex,
   input  logic [KEY_BITS-1:0] wr_key,
   input  logic [AW-1:0]       rd_addr,
   output logic [7:0]          rd_vertex,
   output logic [KEY_BITS-1:0] rd_key
);
   logic [KEY_BITS+7:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_vertex, wr_key};
      end
      {rd_vertex, rd_key} <= mem[rd_addr];
   end

endmodule

@@ design/indexed_min_heap_decrease_key_top.sv @@
// Indexed binary min-heap of (vertex, key) pairs with a per-vertex position map.
// Commands take one transfer each and run to completion before the next is taken:
// a sift walks up one level at a time through S_UP_RD and S_UP_CMP and down through
// S_DN_RD, S_DN_L and S_DN_CMP (one read port on the heap memory and one on the
// position memory set the pace); a query or a refused load is the shortest command,
// an extract that sifts to a leaf the longest, and a result held under rsp_stall
// delays the next command further.
// After reset the position memory is cleared one entry a cycle, all 256 entries, during
// which req_stall stays high. A result waits in an output register until taken.
module indexed_min_heap_decrease_key_top #(
   parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  imh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output imh_pkg::rsp_type rsp_data
);
   import imh_pkg::*;

   localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int PW = AW + 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [PW-1:0] NOPOS = '1;
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0] clr_ff, clr_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [7:0] vtx_ff, vtx_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] oth_ff, oth_in;
   logic [7:0] cv_ff, cv_in;
   logic [KEY_BITS-1:0] ck_ff, ck_in;
   logic [7:0] lv_ff, lv_in;
   logic [KEY_BITS-1:0] lk_ff, lk_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   logic pw_en;
   logic [7:0] pw_addr, pr_addr;
   logic [PW-1:0] pw_data, pr_data;
   logic hw_en;
   logic [AW-1:0] hw_addr, hr_addr;
   logic [7:0] hw_vtx, hr_vtx;
   logic [KEY_BITS-1:0] hw_key, hr_key;
   logic present;
   logic [CW-1:0] child;

   imh_pos_mem #(.PW(PW)) u_pos (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data)
   );

   imh_heap_mem #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .AW(AW)) u_heap (
      .clock(clock), .wr_en(hw_en), .wr_addr(hw_addr), .wr_vertex(hw_vtx),
      .wr_key(hw_key), .rd_addr(hr_addr), .rd_vertex(hr_vtx), .rd_key(hr_key)
   );

   assign present = (pr_data != NOPOS) && (CW'(pr_data) < count_ff);
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      cmd_ff <= cmd_in;
      vtx_ff <= vtx_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      oth_ff <= oth_in;
      cv_ff  <= cv_in;
      ck_ff  <= ck_in;
      lv_ff  <= lv_in;
      lk_ff  <= lk_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      vtx_in = vtx_ff;
      key_in = key_ff;
      idx_in = idx_ff;
      oth_in = oth_ff;
      cv_in = cv_ff;
      ck_in = ck_ff;
      lv_in = lv_ff;
      lk_in = lk_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff && rsp_stall;
      pw_en = 1'b0;
      pw_addr = vtx_ff;
      pw_data = NOPOS;
      pr_addr = vtx_ff;
      hw_en = 1'b0;
      hw_addr = idx_ff[AW-1:0];
      hw_vtx = cv_ff;
      hw_key = ck_ff;
      hr_addr = idx_ff[AW-1:0];
      child = '0;
      unique case (state_ff)
         S_CLEAR: begin
            pw_en = 1'b1;
            pw_addr = clr_ff;
            clr_in = clr_ff + 8'd1;
            if (clr_ff == 8'hFF) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            pr_addr = req_data.vertex;
            hr_addr = '0;
            if (req_valid && !rv_ff) begin
               cmd_in = req_data.command;
               vtx_in = req_data.vertex;
               key_in = KEY_BITS'(req_data.key_in);
               rsp_in.status = ST_OK;
               rsp_in.vertex_out = req_data.vertex;
               rsp_in.key_out = '0;
               rsp_in.in_heap = 1'b0;
               state_in = S_POS;
            end
         end
         S_POS: begin
            // position read is valid now; root read valid too
            hr_addr = pr_data[AW-1:0];
            unique case (cmd_type'(cmd_ff))
               CMD_LOAD: begin
                  if (present) begin
                     rsp_in.status = ST_REJECT;
                     state_in = S_DONE;
                  end else if (count_ff >= CAP) begin
                     rsp_in.status = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     cv_in = vtx_ff;
                     ck_in = key_ff;
                     idx_in = count_ff;
                     count_in = count_ff + 1'b1;
                     state_in = S_UP_RD;
                  end
               end
               CMD_DEC: begin
                  if (!present) begin
                     rsp_in.status = ST_REJECT;
                     state_in = S_DONE;
                  end else begin
                     idx_in = CW'(pr_data);
                     state_in = S_CHECK;
                  end
               end
               CMD_EXTRACT: begin
                  if (count_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     rsp_in.vertex_out = hr_vtx;
                     rsp_in.key_out = 31'(hr_key);
                     pw_en = 1'b1;
                     pw_addr = hr_vtx;
                     pw_data = NOPOS;
                     count_in = count_ff - 1'b1;
                     idx_in = count_ff - 1'b1;
                     hr_addr = AW'(count_ff - 1'b1);
                     state_in = S_ROOT;
                  end
               end
               CMD_QUERY: begin
                  rsp_in.in_heap = present;
                  state_in = S_DONE;
               end
            endcase
         end
         S_CHECK: begin
            if (!(key_ff < hr_key)) begin
               rsp_in.status = ST_REJECT;
               state_in = S_DONE;
            end else begin
               cv_in = vtx_ff;
               ck_in = key_ff;
               state_in = S_UP_RD;
            end
         end
         S_ROOT: begin
            // last entry read; it becomes the hole's value
            cv_in = hr_vtx;
            ck_in = hr_key;
            idx_in = '0;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ROOT2;
            end
         end
         S_ROOT2: begin
            hr_addr = '0;
            state_in = S_DN_RD;
         end
         S_UP_RD: begin
            if (idx_ff == '0) begin
               hw_en = 1'b1;
               pw_en = 1'b1;
               pw_addr = cv_ff;
               pw_data = PW'(idx_ff);
               state_in = S_DONE;
            end else begin
               oth_in = (idx_ff - 1'b1) >> 1;
               hr_addr = AW'((idx_ff - 1'b1) >> 1);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            hw_en = 1'b1;
            pw_en = 1'b1;
            if (ck_ff < hr_key) begin
               hw_vtx = hr_vtx;
               hw_key = hr_key;
               pw_addr = hr_vtx;
               pw_data = PW'(idx_ff);
               idx_in = oth_ff;
               state_in = S_UP_RD;
            end else begin
               pw_addr = cv_ff;
               pw_data = PW'(idx_ff);
               state_in = S_DONE;
            end
         end
         S_DN_RD: begin
            child = CW'({idx_ff, 1'b0}) + 1'b1;
            if ({idx_ff, 1'b1} >= {1'b0, count_ff}) begin
               hw_en = 1'b1;
               pw_en = 1'b1;
               pw_addr = cv_ff;
               pw_data = PW'(idx_ff);
               state_in = S_DONE;
            end else begin
               oth_in = child;
               hr_addr = child[AW-1:0];
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            lv_in = hr_vtx;
            lk_in = hr_key;
            child = oth_ff + 1'b1;
            hr_addr = child[AW-1:0];
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            child = oth_ff + 1'b1;
            hw_en = 1'b1;
            pw_en = 1'b1;
            if ((child < count_ff) && (hr_key < lk_ff) && (hr_key < ck_ff)) begin
               hw_vtx = hr_vtx;
               hw_key = hr_key;
               pw_addr = hr_vtx;
               pw_data = PW'(idx_ff);
               idx_in = child;
               state_in = S_DN_RD;
            end else if (lk_ff < ck_ff) begin
               hw_vtx = lv_ff;
               hw_key = lk_ff;
               pw_addr = lv_ff;
               pw_data = PW'(idx_ff);
               idx_in = oth_ff;
               state_in = S_DN_RD;
            end else begin
               pw_addr = cv_ff;
               pw_data = PW'(idx_ff);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_in.heap_count = 9'(count_ff);
            rsp_in.empty_res = (count_ff == '0);
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
